// ===== rtl/core/aco_pkg.sv =====
// aco_pkg: shared sizes, types and codes of the aho-corasick matcher
// no dependencies
package aco_pkg;

    localparam int NODES    = 16384;
    localparam int NODE_W   = 14;
    localparam int CNTN_W   = NODE_W + 1;
    localparam int ALPHA    = 26;
    localparam int SYM_W    = 5;
    localparam int PATTERNS = 256;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 32;
    localparam int MATCH_W  = 9;
    localparam int OP_W     = 3;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_BUILD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ALPHA-1:0][NODE_W-1:0] row_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_CLEAR,
        K_INSERT,
        K_BUILD,
        K_SCAN,
        K_SCAN_BAD,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [SYM_W-1:0]  symbol;
        logic              last_letter;
        logic [ID_W-1:0]   pattern_id;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS,
        ST_SCN_ROW,
        ST_SCN_WALK,
        ST_SCN_META,
        ST_SCN_CNT,
        ST_READ,
        ST_BLD_ROOT,
        ST_BLD_RPUSH,
        ST_BLD_POP,
        ST_BLD_Q,
        ST_BLD_F,
        ST_BLD_FW,
        ST_BLD_LOOP,
        ST_BLD_WR,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/aco_ifs.sv =====
// aco_req_if and aco_rsp_if: valid/ready channels of the matcher
// depends on aco_pkg
interface aco_req_if;
    import aco_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SYM_W-1:0]    symbol;
    logic                last_letter;
    logic [ID_W-1:0]     pattern_id;

    modport source (output valid, op, symbol, last_letter, pattern_id, input ready);
    modport sink (input valid, op, symbol, last_letter, pattern_id, output ready);
endinterface

interface aco_rsp_if;
    import aco_pkg::*;
    logic                valid;
    logic                ready;
    logic                status;
    logic [MATCH_W-1:0]  matches_here;
    logic [CNT_W-1:0]    pattern_count;
    logic [CNT_W-1:0]    best_count;

    modport source (output valid, status, matches_here, pattern_count, best_count,
                    input ready);
    modport sink (input valid, status, matches_here, pattern_count, best_count,
                  output ready);
endinterface

// ===== rtl/core/aco_front.sv =====
// aco_front: accepts request words, classifies them and queues them
// depends on aco_pkg and aco_req_if
module aco_front (
    input  logic               clk,
    input  logic               rst_n,
    aco_req_if.sink            req,
    input  aco_pkg::back_stat_t stat,
    output aco_pkg::head_t     head
);
    import aco_pkg::*;

    cmd_t              fifo_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    cmd_t              cls;
    logic              push;
    logic              sym_ok;

    always_comb
    begin
        sym_ok          = req.symbol < SYM_W'(ALPHA);
        cls.symbol      = req.symbol;
        cls.last_letter = req.last_letter;
        cls.pattern_id  = req.pattern_id;
        unique case (req.op)
            OP_CLEAR:  cls.kind = K_CLEAR;
            OP_INSERT: cls.kind = sym_ok ? K_INSERT : K_NOP;
            OP_BUILD:  cls.kind = K_BUILD;
            OP_SCAN:   cls.kind = sym_ok ? K_SCAN : K_SCAN_BAD;
            OP_READ:   cls.kind = K_READ;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign req.ready  = (cnt_reg != (QPTR_W+1)'(QDEPTH)) && !stat.clearing;
    assign push       = req.valid && req.ready;
    assign head.valid = cnt_reg != '0;
    assign head.cmd   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = stat.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(stat.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/aco_back.sv =====
// aco_back: sequencer over the trie, link, count and queue memories
// depends on aco_pkg and aco_rsp_if
module aco_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aco_pkg::head_t      head,
    output aco_pkg::back_stat_t stat,
    aco_rsp_if.source           rsp
);
    import aco_pkg::*;

    row_t            row_mem  [NODES];
    node_t           fail_mem [NODES];
    logic            end_mem  [NODES];
    logic [ID_W-1:0] own_mem  [NODES];
    node_t           q_mem    [NODES];
    logic [CNT_W-1:0] cnt_mem [PATTERNS];

    row_t             row_rd;
    node_t            fail_rd;
    logic             end_rd;
    logic [ID_W-1:0]  own_rd;
    node_t            q_rd;
    logic [CNT_W-1:0] cnt_rd;

    node_t            row_raddr, row_waddr, meta_raddr, fail_waddr, end_waddr;
    node_t            q_raddr, q_waddr;
    logic [ID_W-1:0]  cnt_raddr, cnt_waddr;
    row_t             row_wdata;
    node_t            fail_wdata, q_wdata;
    logic             end_wdata;
    logic [CNT_W-1:0] cnt_wdata;
    logic             row_we, fail_we, end_we, own_we, q_we, cnt_we;

    state_t              state_reg, state_next;
    node_t               clr_addr_reg, clr_addr_next;
    logic [CNTN_W-1:0]   node_count_reg, node_count_next;
    node_t               ins_cur_reg, ins_cur_next;
    node_t               scan_cur_reg, scan_cur_next;
    logic                built_reg, built_next;
    logic [CNT_W-1:0]    max_reg, max_next;
    logic                pend_reg, pend_next;
    node_t               q_head_reg, q_head_next;
    node_t               q_tail_reg, q_tail_next;
    logic                out_valid_reg, out_valid_next;

    cmd_t                cmd_reg, cmd_next;
    node_t               walk_reg, walk_next;
    logic [MATCH_W-1:0]  found_reg, found_next;
    logic [ID_W-1:0]     id_reg, id_next;
    node_t               cur_reg, cur_next;
    row_t                rowc_reg, rowc_next;
    row_t                rowf_reg, rowf_next;
    logic [SYM_W-1:0]    idx_reg, idx_next;
    logic                res_status_reg, res_status_next;
    logic [MATCH_W-1:0]  res_match_reg, res_match_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic                out_status_reg, out_status_next;
    logic [MATCH_W-1:0]  out_match_reg, out_match_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic [CNT_W-1:0]    out_best_reg, out_best_next;

    node_t               child;
    logic [CNT_W-1:0]    cnt_inc;
    logic                pop;

    assign stat.pop       = pop;
    assign stat.clearing  = state_reg == ST_CLEAR;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.matches_here  = out_match_reg;
    assign rsp.pattern_count = out_count_reg;
    assign rsp.best_count    = out_best_reg;

    assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        node_count_next = node_count_reg;
        ins_cur_next    = ins_cur_reg;
        scan_cur_next   = scan_cur_reg;
        built_next      = built_reg;
        max_next        = max_reg;
        pend_next       = pend_reg;
        q_head_next     = q_head_reg;
        q_tail_next     = q_tail_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        walk_next       = walk_reg;
        found_next      = found_reg;
        id_next         = id_reg;
        cur_next        = cur_reg;
        rowc_next       = rowc_reg;
        rowf_next       = rowf_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_match_next  = res_match_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_match_next  = out_match_reg;
        out_count_next  = out_count_reg;
        out_best_next   = out_best_reg;
        pop        = 1'b0;
        child      = '0;
        row_raddr  = '0;
        row_waddr  = '0;
        row_wdata  = '0;
        row_we     = 1'b0;
        meta_raddr = '0;
        fail_waddr = '0;
        fail_wdata = '0;
        fail_we    = 1'b0;
        end_waddr  = '0;
        end_wdata  = 1'b0;
        end_we     = 1'b0;
        own_we     = 1'b0;
        q_raddr    = '0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_we       = 1'b0;
        cnt_raddr  = '0;
        cnt_waddr  = '0;
        cnt_wdata  = '0;
        cnt_we     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                row_we     = 1'b1;
                row_waddr  = clr_addr_reg;
                fail_we    = 1'b1;
                fail_waddr = clr_addr_reg;
                end_we     = 1'b1;
                end_waddr  = clr_addr_reg;
                if (clr_addr_reg < NODE_W'(PATTERNS))
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = clr_addr_reg[ID_W-1:0];
                end
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == node_t'(NODES - 1))
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                res_status_next = 1'b0;
                res_match_next  = '0;
                res_count_next  = '0;
                cnt_raddr       = head.cmd.pattern_id;
                unique case (head.cmd.kind)
                    K_INSERT: row_raddr = ins_cur_reg;
                    K_SCAN:   row_raddr = scan_cur_reg;
                    default:  row_raddr = '0;
                endcase
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    unique case (head.cmd.kind)
                        K_CLEAR:
                        begin
                            node_count_next = CNTN_W'(1);
                            ins_cur_next    = '0;
                            scan_cur_next   = '0;
                            max_next        = '0;
                            built_next      = 1'b0;
                            clr_addr_next   = '0;
                            pend_next       = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        K_INSERT:   state_next = built_reg ? ST_OUT : ST_INS;
                        K_SCAN:     state_next = ST_SCN_ROW;
                        K_SCAN_BAD:
                        begin
                            scan_cur_next = '0;
                            state_next    = ST_OUT;
                        end
                        K_BUILD:
                        begin
                            built_next  = 1'b1;
                            q_head_next = '0;
                            q_tail_next = '0;
                            state_next  = built_reg ? ST_OUT : ST_BLD_ROOT;
                        end
                        K_READ:     state_next = ST_READ;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_INS:
            begin
                child      = row_rd[cmd_reg.symbol];
                state_next = ST_OUT;
                if (child == '0 && node_count_reg == CNTN_W'(NODES))
                begin
                    res_status_next = 1'b1;
                    if (cmd_reg.last_letter)
                    begin
                        ins_cur_next = '0;
                    end
                end
                else
                begin
                    if (child == '0)
                    begin
                        child                      = node_count_reg[NODE_W-1:0];
                        node_count_next            = node_count_reg + 1'b1;
                        row_we                     = 1'b1;
                        row_waddr                  = ins_cur_reg;
                        row_wdata                  = row_rd;
                        row_wdata[cmd_reg.symbol]  = child;
                    end
                    if (cmd_reg.last_letter)
                    begin
                        end_we       = 1'b1;
                        end_waddr    = child;
                        end_wdata    = 1'b1;
                        own_we       = 1'b1;
                        ins_cur_next = '0;
                    end
                    else
                    begin
                        ins_cur_next = child;
                    end
                end
            end
            ST_SCN_ROW:
            begin
                walk_next     = row_rd[cmd_reg.symbol];
                scan_cur_next = row_rd[cmd_reg.symbol];
                found_next    = '0;
                state_next    = ST_SCN_WALK;
            end
            ST_SCN_WALK:
            begin
                meta_raddr = walk_reg;
                if (walk_reg == '0)
                begin
                    res_match_next = found_reg;
                    state_next     = ST_OUT;
                end
                else
                begin
                    state_next = ST_SCN_META;
                end
            end
            ST_SCN_META:
            begin
                walk_next = fail_rd;
                cnt_raddr = own_rd;
                id_next   = own_rd;
                if (end_rd)
                begin
                    if (found_reg != '1)
                    begin
                        found_next = found_reg + 1'b1;
                    end
                    state_next = ST_SCN_CNT;
                end
                else
                begin
                    state_next = ST_SCN_WALK;
                end
            end
            ST_SCN_CNT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = id_reg;
                cnt_wdata = cnt_inc;
                if (cnt_inc > max_reg)
                begin
                    max_next = cnt_inc;
                end
                state_next = ST_SCN_WALK;
            end
            ST_READ:
            begin
                res_count_next = cnt_rd;
                state_next     = ST_OUT;
            end
            ST_BLD_ROOT:
            begin
                rowc_next  = row_rd;
                idx_next   = '0;
                state_next = ST_BLD_RPUSH;
            end
            ST_BLD_RPUSH:
            begin
                child = rowc_reg[idx_reg];
                if (child != '0)
                begin
                    q_we        = 1'b1;
                    q_waddr     = q_tail_reg;
                    q_wdata     = child;
                    q_tail_next = q_tail_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == SYM_W'(ALPHA - 1)) ? ST_BLD_POP : ST_BLD_RPUSH;
            end
            ST_BLD_POP:
            begin
                q_raddr = q_head_reg;
                if (q_head_reg == q_tail_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    q_head_next = q_head_reg + 1'b1;
                    state_next  = ST_BLD_Q;
                end
            end
            ST_BLD_Q:
            begin
                cur_next   = q_rd;
                row_raddr  = q_rd;
                meta_raddr = q_rd;
                state_next = ST_BLD_F;
            end
            ST_BLD_F:
            begin
                rowc_next  = row_rd;
                row_raddr  = fail_rd;
                state_next = ST_BLD_FW;
            end
            ST_BLD_FW:
            begin
                rowf_next  = row_rd;
                idx_next   = '0;
                state_next = ST_BLD_LOOP;
            end
            ST_BLD_LOOP:
            begin
                child = rowc_reg[idx_reg];
                if (child != '0)
                begin
                    fail_we     = 1'b1;
                    fail_waddr  = child;
                    fail_wdata  = rowf_reg[idx_reg];
                    q_we        = 1'b1;
                    q_waddr     = q_tail_reg;
                    q_wdata     = child;
                    q_tail_next = q_tail_reg + 1'b1;
                end
                else
                begin
                    rowc_next[idx_reg] = rowf_reg[idx_reg];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == SYM_W'(ALPHA - 1)) ? ST_BLD_WR : ST_BLD_LOOP;
            end
            ST_BLD_WR:
            begin
                row_we     = 1'b1;
                row_waddr  = cur_reg;
                row_wdata  = rowc_reg;
                state_next = ST_BLD_POP;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_match_next  = res_match_reg;
                    out_count_next  = res_count_reg;
                    out_best_next   = max_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            node_count_reg <= CNTN_W'(1);
            ins_cur_reg    <= '0;
            scan_cur_reg   <= '0;
            built_reg      <= 1'b0;
            max_reg        <= '0;
            pend_reg       <= 1'b0;
            q_head_reg     <= '0;
            q_tail_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            node_count_reg <= node_count_next;
            ins_cur_reg    <= ins_cur_next;
            scan_cur_reg   <= scan_cur_next;
            built_reg      <= built_next;
            max_reg        <= max_next;
            pend_reg       <= pend_next;
            q_head_reg     <= q_head_next;
            q_tail_reg     <= q_tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        walk_reg       <= walk_next;
        found_reg      <= found_next;
        id_reg         <= id_next;
        cur_reg        <= cur_next;
        rowc_reg       <= rowc_next;
        rowf_reg       <= rowf_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_match_reg  <= res_match_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_match_reg  <= out_match_next;
        out_count_reg  <= out_count_next;
        out_best_reg   <= out_best_next;
    end

    // memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rd <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rd <= fail_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem[end_waddr] <= end_wdata;
        end
        end_rd <= end_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[end_waddr] <= cmd_reg.pattern_id;
        end
        own_rd <= own_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd <= q_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd <= cnt_mem[cnt_raddr];
    end

endmodule

// ===== rtl/core/aho_corasick_matcher_unit.sv =====
// aho_corasick_matcher_unit: top level, front queue plus back sequencer
// depends on aco_pkg, aco_ifs, aco_front and aco_back
//
// req carries one command word (op, symbol, last_letter, pattern_id);
// rsp returns exactly one result word per command, in order.
// the front takes words into a four-deep queue; the back runs them one at
// a time against trie, link, mark, owner and count memories, each with one write and one read port.
// work per word in the back sequencer, which uses registered memory reads:
//   insert, read count: one memory read, then the result
//   undefined op, dropped or out-of-range letter, insert after build,
//   build after build: straight to the result
//   scan: one row read, then a walk of the failure chain with a count update per marked node
//   build: a breadth-first pass over every trie node below the root (a step per letter plus row reads/write)
//   clear: one trie row, link and mark entry per cycle
// after reset the same clearing pass runs; req.ready is low
// for its whole length and for the pass of every clear.
// the result sits in an output register; while rsp.ready is low the
// front keeps taking words until its queue is full.
module aho_corasick_matcher_unit (
    input  logic clk,
    input  logic rst_n,
    aco_req_if.sink   req,
    aco_rsp_if.source rsp
);
    import aco_pkg::*;

    head_t      head;
    back_stat_t stat;

    aco_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat),
        .head  (head)
    );

    aco_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .stat  (stat),
        .rsp   (rsp)
    );

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !req.ready)
        else $error("word taken during clearing pass");

    a_match_gives_best: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.matches_here != '0) |-> rsp.best_count != '0)
        else $error("match reported with zero best count");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |-> (rsp.matches_here == '0 && rsp.pattern_count == '0))
        else $error("full status on a non-insert word");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> head.valid)
        else $error("queue popped while empty");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking regression of aho_corasick_matcher_unit
// drives command words on req, predicts each result word (or takes a fixed one), checks rsp in order
// depends on aco_pkg, aco_ifs and the matcher rtl
`timescale 1ns / 100ps

module testbench;
    import aco_pkg::*;

    typedef struct {
        logic                status;
        logic [MATCH_W-1:0]  nmatch;
        logic [CNT_W-1:0]    pcount;
        logic [CNT_W-1:0]    best;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [ID_W-1:0]  id;
        bit               typed;
        result_t          res;
    } dir_row_t;

    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    aco_req_if req ();
    aco_rsp_if rsp ();

    aho_corasick_matcher_unit dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // trie shadow
    node_t            kid [NODES][ALPHA];
    node_t            fail_of [NODES];
    bit               mark_of [NODES];
    logic [ID_W-1:0]  owner_of [NODES];
    node_t            bfs [NODES];
    logic [CNT_W-1:0] hits [PATTERNS];
    logic [CNT_W-1:0] best_hits;
    int               node_cnt;
    node_t            ins_cur;
    node_t            scan_cur;
    bit               linked;

    result_t pending_results [$];
    int      errors;
    int      cycles;
    bit      calm;
    bit      hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void wipe_trie();
        for (int n = 0; n < NODES; n++)
        begin
            for (int a = 0; a < ALPHA; a++)
                kid[n][a] = '0;
            fail_of[n] = '0;
            mark_of[n] = 1'b0;
            owner_of[n] = '0;
        end
        for (int p = 0; p < PATTERNS; p++)
            hits[p] = '0;
        node_cnt = 1;
        ins_cur = '0;
        scan_cur = '0;
        best_hits = '0;
        linked = 1'b0;
    endfunction

    function automatic logic add_letter(logic [SYM_W-1:0] sym, logic last, logic [ID_W-1:0] id);
        node_t cur;
        node_t nxt;
        if (linked || sym >= ALPHA)
            return 1'b0;
        cur = ins_cur;
        nxt = kid[cur][sym];
        if (nxt == '0)
        begin
            if (node_cnt >= NODES)
            begin
                if (last)
                    ins_cur = '0;
                return 1'b1;
            end
            nxt = node_t'(node_cnt);
            node_cnt++;
            for (int a = 0; a < ALPHA; a++)
                kid[nxt][a] = '0;
            fail_of[nxt] = '0;
            mark_of[nxt] = 1'b0;
            owner_of[nxt] = '0;
            kid[cur][sym] = nxt;
        end
        if (last)
        begin
            mark_of[nxt] = 1'b1;
            owner_of[nxt] = id;
            ins_cur = '0;
        end
        else
            ins_cur = nxt;
        return 1'b0;
    endfunction

    function automatic void link_trie();
        int head;
        int tail;
        node_t cur;
        node_t f;
        node_t c;
        head = 0;
        tail = 0;
        if (linked)
            return;
        linked = 1'b1;
        for (int a = 0; a < ALPHA; a++)
            if (kid[0][a] != '0 && tail < NODES)
                bfs[tail++] = kid[0][a];
        while (head < tail)
        begin
            cur = bfs[head++];
            f = fail_of[cur];
            for (int a = 0; a < ALPHA; a++)
            begin
                c = kid[cur][a];
                if (c != '0)
                begin
                    fail_of[c] = kid[f][a];
                    if (tail < NODES)
                        bfs[tail++] = c;
                end
                else
                    kid[cur][a] = kid[f][a];
            end
        end
    endfunction

    function automatic logic [MATCH_W-1:0] scan_text(logic [SYM_W-1:0] sym);
        node_t t;
        int steps;
        logic [MATCH_W-1:0] found;
        steps = 0;
        found = '0;
        if (sym >= ALPHA)
        begin
            scan_cur = '0;
            return '0;
        end
        scan_cur = kid[scan_cur][sym];
        t = scan_cur;
        while (t != '0 && steps < NODES)
        begin
            if (mark_of[t])
            begin
                if (found < 511)
                    found++;
                if (hits[owner_of[t]] != '1)
                    hits[owner_of[t]]++;
                if (hits[owner_of[t]] > best_hits)
                    best_hits = hits[owner_of[t]];
            end
            t = fail_of[t];
            steps++;
        end
        return found;
    endfunction

    function automatic result_t predict_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                             logic last, logic [ID_W-1:0] id);
        result_t r;
        r.status = 1'b0;
        r.nmatch = '0;
        r.pcount = '0;
        case (op)
            OP_CLEAR:  wipe_trie();
            OP_INSERT: r.status = add_letter(sym, last, id);
            OP_BUILD:  link_trie();
            OP_SCAN:   r.nmatch = scan_text(sym);
            OP_READ:   r.pcount = hits[id];
            default:   ;
        endcase
        r.best = best_hits;
        return r;
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic last,
                             logic [ID_W-1:0] id, bit typed = 1'b0,
                             result_t typed_res = '{default: '0});
        result_t r;
        if (!calm && $urandom_range(99) < 13)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.symbol <= sym;
        req.last_letter <= last;
        req.pattern_id <= id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = predict_word(op, sym, last, id);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker and receiver stalls
    initial begin
        result_t e;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending");
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status expected %0d got %0d", e.status, rsp.status);
                        errors++;
                    end
                    if (rsp.matches_here !== e.nmatch)
                    begin
                        $error("matches_here expected %0d got %0d", e.nmatch, rsp.matches_here);
                        errors++;
                    end
                    if (rsp.pattern_count !== e.pcount)
                    begin
                        $error("pattern_count expected %0d got %0d", e.pcount, rsp.pattern_count);
                        errors++;
                    end
                    if (rsp.best_count !== e.best)
                    begin
                        $error("best_count expected %0d got %0d", e.best, rsp.best_count);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    dir_row_t dir_rows [$];

    function automatic void add_row(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic last,
                                    logic [ID_W-1:0] id, bit typed = 1'b0);
        dir_row_t w;
        w.op = op;
        w.sym = sym;
        w.last = last;
        w.id = id;
        w.typed = typed;
        w.res = '{default: '0};
        dir_rows.push_back(w);
    endfunction

    task automatic random_phase(int alpha_hi, bit squeeze);
        int npat;
        int len;
        logic [ID_W-1:0] ids [$];
        logic [ID_W-1:0] id;
        send_word(OP_CLEAR, 5'($urandom), 1'($urandom), 8'($urandom));
        npat = $urandom_range(2, 8);
        for (int p = 0; p < npat; p++)
        begin
            len = $urandom_range(1, 4);
            id = 8'($urandom);
            ids.push_back(id);
            for (int k = 0; k < len; k++)
                send_word(OP_INSERT,
                          ($urandom_range(9) == 0) ? 5'($urandom_range(26, 31))
                                                   : 5'($urandom_range(0, alpha_hi)),
                          k == len - 1, (k == len - 1) ? id : 8'($urandom));
        end
        if ($urandom_range(1))
            for (int k = 0; k < 4; k++)
                send_word(OP_SCAN, 5'($urandom_range(0, alpha_hi)), 1'($urandom), 8'($urandom));
        send_word(3'($urandom_range(5, 7)), 5'($urandom), 1'($urandom), 8'($urandom));
        send_word(OP_BUILD, 5'($urandom), 1'($urandom), 8'($urandom));
        if ($urandom_range(1))
            send_word(OP_BUILD, 5'($urandom), 1'($urandom), 8'($urandom));
        send_word(OP_INSERT, 5'($urandom_range(0, 25)), 1'($urandom), 8'($urandom));
        if (squeeze)
            hold_req = 1'b1;
        for (int k = 0; k < 45; k++)
            send_word(OP_SCAN,
                      ($urandom_range(19) == 0) ? 5'($urandom_range(26, 31))
                                                : 5'($urandom_range(0, alpha_hi)),
                      1'($urandom), 8'($urandom));
        foreach (ids[i])
            send_word(OP_READ, 5'($urandom), 1'($urandom), ids[i]);
        for (int k = 0; k < 3; k++)
            send_word(OP_READ, 5'($urandom), 1'($urandom), 8'($urandom));
        drain();
    endtask

    initial begin
        dir_row_t w;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        req.valid = 1'b0;
        req.op = OP_READ;
        req.symbol = '0;
        req.last_letter = 1'b0;
        req.pattern_id = '0;
        wipe_trie();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_row(OP_READ, 5'd0, 1'b0, 8'd0, 1'b1);
        add_row(3'd5, 5'd31, 1'b1, 8'd255, 1'b1);
        add_row(3'd7, 5'd0, 1'b0, 8'd0, 1'b1);
        add_row(OP_INSERT, 5'd31, 1'b1, 8'd9, 1'b1);
        add_row(OP_INSERT, 5'd7, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd4, 1'b1, 8'd1);
        add_row(OP_INSERT, 5'd18, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd7, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd4, 1'b1, 8'd2);
        add_row(OP_INSERT, 5'd7, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd8, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd18, 1'b1, 8'd255);
        add_row(OP_SCAN, 5'd7, 1'b0, 8'd0);
        add_row(OP_SCAN, 5'd4, 1'b0, 8'd0);
        add_row(OP_BUILD, 5'd0, 1'b0, 8'd0);
        add_row(OP_BUILD, 5'd0, 1'b0, 8'd0);
        add_row(OP_INSERT, 5'd0, 1'b1, 8'd3);
        add_row(OP_SCAN, 5'd20, 1'b0, 8'd0);
        add_row(OP_SCAN, 5'd18, 1'b0, 8'd0);
        add_row(OP_SCAN, 5'd7, 1'b0, 8'd0);
        add_row(OP_SCAN, 5'd4, 1'b0, 8'd0);
        add_row(OP_SCAN, 5'd31, 1'b0, 8'd0);
        add_row(OP_READ, 5'd0, 1'b0, 8'd1);
        add_row(OP_READ, 5'd0, 1'b0, 8'd2);
        add_row(OP_READ, 5'd0, 1'b0, 8'd255);
        foreach (dir_rows[i])
        begin
            w = dir_rows[i];
            send_word(w.op, w.sym, w.last, w.id, w.typed, w.res);
        end
        drain();

        random_phase(2, 1'b0);
        random_phase(25, 1'b1);
        random_phase(3, 1'b0);

        // steady stretch with no idling on either side
        calm = 1'b1;
        random_phase(4, 1'b0);
        calm = 1'b0;

        random_phase(1, 1'b0);
        random_phase(25, 1'b0);

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/aco_pkg.sv
rtl/core/aco_ifs.sv
rtl/core/aco_front.sv
rtl/core/aco_back.sv
rtl/core/aho_corasick_matcher_unit.sv
tb/testbench.sv
